>>> hw/rtl/rank_two_null_vector_assert.svh
// assertion macros for the rank-two null vector block
`ifndef RANK_TWO_NULL_VECTOR_ASSERT_SVH
`define RANK_TWO_NULL_VECTOR_ASSERT_SVH

// same-cycle implication
`define RTNV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTNV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rtnv_pkg.sv
// constants, types and output scaling for the rank-two null vector block
package rtnv_pkg;

    localparam int ENTRY_W   = 16;
    localparam int TOL_W     = 16;
    localparam int OUT_W     = 32;
    localparam int NUM_STG   = 7;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    localparam int IN_DATA_W  = 9 * ENTRY_W;
    localparam int IN_BYTES_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * OUT_W;

    localparam int PROD_W  = 2 * ENTRY_W;
    localparam int ESQ_W   = 2 * ENTRY_W - 1;
    localparam int FP_W    = ESQ_W + 2;
    localparam int FROB_W  = 2 * ENTRY_W + 2;
    localparam int CR_W    = 2 * ENTRY_W;
    localparam int CSQ_W   = 2 * CR_W - 2;
    localparam int NORM_W  = CSQ_W + 2;
    localparam int TF_W    = TOL_W + FROB_W;
    localparam int LO_W    = (TF_W + 1) / 2;
    localparam int HI_W    = TF_W - LO_W;
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + LO_W;
    localparam int LL_W    = 2 * LO_W;
    localparam int BOUND_W = 2 * TF_W;
    localparam int CMP_W   = (NORM_W + 2 * TOL_W > BOUND_W) ? NORM_W + 2 * TOL_W : BOUND_W;

    localparam int SHIFT_R = (ENTRY_W >= 16) ? 2 * (ENTRY_W - 16) : 0;
    localparam int SHIFT_L = (ENTRY_W < 16) ? 2 * (16 - ENTRY_W) : 0;
    localparam int SCL_W   = CR_W + SHIFT_L;

    localparam logic signed [SCL_W-1:0] SAT_HI = SCL_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [SCL_W-1:0] SAT_LO = ~SAT_HI;

    // column pairs of the cross products, earlier pair wins a tie
    localparam logic [1:0] PAIR_COL [3][2] = '{'{2'd0, 2'd1}, '{2'd0, 2'd2}, '{2'd1, 2'd2}};

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CR_W-1:0]    t_cross;
    typedef logic [ESQ_W-1:0]          t_esq;
    typedef logic [CSQ_W-1:0]          t_csq;
    typedef logic [NORM_W-1:0]         t_norm;
    typedef logic [OUT_W-1:0]          t_out;

    // rescale to q5.26, floor on right shift, then saturate
    function automatic t_out scale_sat(input t_cross v);
        logic signed [SCL_W-1:0] s;
        s = SCL_W'(v);
        s = s <<< SHIFT_L;
        s = s >>> SHIFT_R;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[OUT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/rank_two_null_vector.sv
// rank-two 3x3 null vector by best column-pair cross product, seven-stage pipeline
//
// Input stream s_axis: one 3x3 matrix of signed q2.13 entries per transfer in
// tdata, row-major from the lowest bit; tuser set means the matrix is transposed
// first (left null vector). Output stream m_axis: the cross product of the column
// pair with the largest squared norm as three signed q5.26 words in tdata, and in
// tuser a flag that the matrix is nonzero and that norm exceeds the tolerance bound.
// The tolerance (unsigned q0.16) is written through i_cfg_wr_en / i_cfg_wr_data.
// The result passes through stage registers s1 to s6 and then the output register,
// and one matrix is taken every cycle unless a stalled receiver holds the pipeline.
// Each stage holds about one multiply or one wide add, and the 50x50 bound square
// is split into three 25x25 partial products.
// Every stage carries a valid bit; a stage loads when it is empty or its successor
// loads, so a stalled receiver holds the output and only bubbles ahead of it fill.
// Reset clears all valid bits and sets the tolerance to 1.
module rank_two_null_vector
    import rtnv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [TOL_W-1:0]      i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_r0_c0, r0_c1, r0_c2, r1_c0, r1_c1, r1_c2, r2_c0, r2_c1, r2_c2
    input  logic [IN_BYTES_W-1:0] s_axis_tdata,
    // use_rows
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // null_x, null_y, null_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // valid_res
    output logic                  m_axis_tuser
);

    logic [TOL_W-1:0]   r_tol;
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_open;

    t_entry w_m [3][3];

    t_prod  n_s1_prod [3][6];
    t_esq   n_s1_esq  [9];
    t_prod  r_s1_prod [3][6];
    t_esq   r_s1_esq  [9];

    t_cross n_s2_cr [3][3];
    logic [FP_W-1:0] n_s2_fp [3];
    t_cross r_s2_cr [3][3];
    logic [FP_W-1:0] r_s2_fp [3];

    t_csq   n_s3_csq [3][3];
    logic [FROB_W-1:0] n_s3_frob;
    t_cross r_s3_cr  [3][3];
    t_csq   r_s3_csq [3][3];
    logic [FROB_W-1:0] r_s3_frob;

    t_norm  n_s4_norm [3];
    logic [TF_W-1:0] n_s4_tf;
    t_cross r_s4_cr   [3][3];
    t_norm  r_s4_norm [3];
    logic [TF_W-1:0] r_s4_tf;

    t_out   n_s5_vec [3];
    t_norm  n_s5_norm;
    logic [HH_W-1:0] n_s5_hh;
    logic [HL_W-1:0] n_s5_hl;
    logic [LL_W-1:0] n_s5_ll;
    t_out   r_s5_vec [3];
    t_norm  r_s5_norm;
    logic [HH_W-1:0] r_s5_hh;
    logic [HL_W-1:0] r_s5_hl;
    logic [LL_W-1:0] r_s5_ll;

    logic [BOUND_W-1:0] n_s6_bound;
    t_out   r_s6_vec [3];
    t_norm  r_s6_norm;
    logic [BOUND_W-1:0] r_s6_bound;

    logic   n_out_flag;
    t_out   r_out_vec [3];
    logic   r_out_flag;

    // stage load chain
    always_comb begin
        w_open[NUM_STG-1] = !r_vld[NUM_STG-1] || m_axis_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_open[k] = !r_vld[k] || w_open[k+1];
        end
    end

    assign s_axis_tready = w_open[0];
    assign m_axis_tvalid = r_vld[NUM_STG-1];
    assign m_axis_tdata  = {r_out_vec[2], r_out_vec[1], r_out_vec[0]};
    assign m_axis_tuser  = r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (w_open[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_open[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: transpose select, pair products, entry squares
    always_comb begin
        t_prod sq;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (s_axis_tuser) begin
                    w_m[r][c] = s_axis_tdata[(c*3+r)*ENTRY_W +: ENTRY_W];
                end else begin
                    w_m[r][c] = s_axis_tdata[(r*3+c)*ENTRY_W +: ENTRY_W];
                end
            end
        end
        for (int p = 0; p < 3; p++) begin
            n_s1_prod[p][0] = PROD_W'(w_m[1][PAIR_COL[p][0]]) * PROD_W'(w_m[2][PAIR_COL[p][1]]);
            n_s1_prod[p][1] = PROD_W'(w_m[2][PAIR_COL[p][0]]) * PROD_W'(w_m[1][PAIR_COL[p][1]]);
            n_s1_prod[p][2] = PROD_W'(w_m[2][PAIR_COL[p][0]]) * PROD_W'(w_m[0][PAIR_COL[p][1]]);
            n_s1_prod[p][3] = PROD_W'(w_m[0][PAIR_COL[p][0]]) * PROD_W'(w_m[2][PAIR_COL[p][1]]);
            n_s1_prod[p][4] = PROD_W'(w_m[0][PAIR_COL[p][0]]) * PROD_W'(w_m[1][PAIR_COL[p][1]]);
            n_s1_prod[p][5] = PROD_W'(w_m[1][PAIR_COL[p][0]]) * PROD_W'(w_m[0][PAIR_COL[p][1]]);
        end
        for (int i = 0; i < 9; i++) begin
            sq = PROD_W'(w_m[i/3][i%3]) * PROD_W'(w_m[i/3][i%3]);
            n_s1_esq[i] = sq[ESQ_W-1:0];
        end
    end

    // stage 2: cross components, frobenius partial sums
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            n_s2_cr[p][0] = r_s1_prod[p][0] - r_s1_prod[p][1];
            n_s2_cr[p][1] = r_s1_prod[p][2] - r_s1_prod[p][3];
            n_s2_cr[p][2] = r_s1_prod[p][4] - r_s1_prod[p][5];
        end
        for (int k = 0; k < 3; k++) begin
            n_s2_fp[k] = FP_W'(r_s1_esq[3*k]) + FP_W'(r_s1_esq[3*k+1])
                       + FP_W'(r_s1_esq[3*k+2]);
        end
    end

    // stage 3: component squares, frobenius total
    always_comb begin
        logic signed [2*CR_W-1:0] sq;
        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < 3; i++) begin
                sq = (2*CR_W)'(r_s2_cr[p][i]) * (2*CR_W)'(r_s2_cr[p][i]);
                n_s3_csq[p][i] = sq[CSQ_W-1:0];
            end
        end
        n_s3_frob = FROB_W'(r_s2_fp[0]) + FROB_W'(r_s2_fp[1]) + FROB_W'(r_s2_fp[2]);
    end

    // stage 4: squared norms, tolerance times frobenius
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            n_s4_norm[p] = NORM_W'(r_s3_csq[p][0]) + NORM_W'(r_s3_csq[p][1])
                         + NORM_W'(r_s3_csq[p][2]);
        end
        n_s4_tf = TF_W'(r_tol) * TF_W'(r_s3_frob);
    end

    // stage 5: pick best pair, scale, bound partial products
    always_comb begin
        logic [1:0] sel;
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;
        sel       = 2'd0;
        n_s5_norm = r_s4_norm[0];
        if (r_s4_norm[1] > n_s5_norm) begin
            sel       = 2'd1;
            n_s5_norm = r_s4_norm[1];
        end
        if (r_s4_norm[2] > n_s5_norm) begin
            sel       = 2'd2;
            n_s5_norm = r_s4_norm[2];
        end
        for (int i = 0; i < 3; i++) begin
            n_s5_vec[i] = scale_sat(r_s4_cr[sel][i]);
        end
        lo      = r_s4_tf[LO_W-1:0];
        hi      = r_s4_tf[TF_W-1:LO_W];
        n_s5_hh = HH_W'(hi) * HH_W'(hi);
        n_s5_hl = HL_W'(hi) * HL_W'(lo);
        n_s5_ll = LL_W'(lo) * LL_W'(lo);
    end

    // stage 6: assemble bound
    assign n_s6_bound = (BOUND_W'(r_s5_hh) << (2 * LO_W))
                      + (BOUND_W'(r_s5_hl) << (LO_W + 1))
                      + BOUND_W'(r_s5_ll);

    // stage 7: rank test
    assign n_out_flag = (CMP_W'(r_s6_norm) << (2 * TOL_W)) > CMP_W'(r_s6_bound);

    always_ff @(posedge i_clk) begin
        if (w_open[0]) begin
            r_s1_prod <= n_s1_prod;
            r_s1_esq  <= n_s1_esq;
        end
        if (w_open[1]) begin
            r_s2_cr <= n_s2_cr;
            r_s2_fp <= n_s2_fp;
        end
        if (w_open[2]) begin
            r_s3_cr   <= r_s2_cr;
            r_s3_csq  <= n_s3_csq;
            r_s3_frob <= n_s3_frob;
        end
        if (w_open[3]) begin
            r_s4_cr   <= r_s3_cr;
            r_s4_norm <= n_s4_norm;
            r_s4_tf   <= n_s4_tf;
        end
        if (w_open[4]) begin
            r_s5_vec  <= n_s5_vec;
            r_s5_norm <= n_s5_norm;
            r_s5_hh   <= n_s5_hh;
            r_s5_hl   <= n_s5_hl;
            r_s5_ll   <= n_s5_ll;
        end
        if (w_open[5]) begin
            r_s6_vec   <= r_s5_vec;
            r_s6_norm  <= r_s5_norm;
            r_s6_bound <= n_s6_bound;
        end
        if (w_open[6]) begin
            r_out_vec  <= r_s6_vec;
            r_out_flag <= n_out_flag;
        end
    end

`include "rank_two_null_vector_assert.svh"

    `RTNV_ASSERT_NEXT(a_accept_captured, s_axis_tvalid && s_axis_tready, r_vld[0], "input lost")
    `RTNV_ASSERT_NEXT(a_out_load, r_vld[NUM_STG-2] && w_open[NUM_STG-1], m_axis_tvalid, "dropped")
    `RTNV_ASSERT_NOW(a_flag_vec, m_axis_tvalid && m_axis_tuser, m_axis_tdata != '0, "zero vector")

endmodule
